// ----- rtl/des_rks_pkg.sv -----
`default_nettype none

package des_rks_pkg;

   localparam int HalfBits   = 28;
   localparam int RoundCount = 16;
   localparam int Pc1Bits    = 56;
   localparam int Pc2Bits    = 48;
   localparam int KeyBits    = 64;
   localparam int RoundBits  = 4;
   localparam int RspBytes   = (Pc2Bits + RoundBits + 7) / 8;
   localparam int RspWidth   = RspBytes * 8;

   localparam logic [RoundBits-1:0] LAST_ROUND = RoundBits'(RoundCount - 1);

   // Table entries count bit positions from the MSB, starting at one.
   localparam logic [6:0] PC1_TABLE [0:Pc1Bits-1] = '{
      7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
      7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
      7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
      7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39,
      7'd31, 7'd23, 7'd15, 7'd7,  7'd62, 7'd54, 7'd46, 7'd38,
      7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
      7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
   };

   localparam logic [5:0] PC2_TABLE [0:Pc2Bits-1] = '{
      6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28,
      6'd15, 6'd6,  6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,
      6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
      6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40,
      6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
      6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
   };

   // 1: rotate by two bits this round, 0: by one bit
   localparam logic SHIFT_TWO [0:RoundCount-1] = '{
      1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
      1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0
   };

   typedef struct packed {
      logic                 busy;
      logic                 final_round;
      logic [RoundBits-1:0] round;
   } rks_status_type;

   function automatic logic [Pc1Bits-1:0] pc1(input logic [KeyBits-1:0] key);
      logic [Pc1Bits-1:0] sel;
      sel = '0;
      for (int i = 0; i < Pc1Bits; i++) begin
         sel[Pc1Bits-1-i] = key[KeyBits - int'(PC1_TABLE[i])];
      end
      return sel;
   endfunction

   function automatic logic [Pc2Bits-1:0] pc2(input logic [Pc1Bits-1:0] cd);
      logic [Pc2Bits-1:0] sel;
      sel = '0;
      for (int i = 0; i < Pc2Bits; i++) begin
         sel[Pc2Bits-1-i] = cd[Pc1Bits - int'(PC2_TABLE[i])];
      end
      return sel;
   endfunction

   function automatic logic [HalfBits-1:0] rot28(input logic [HalfBits-1:0] v,
                                                 input logic two);
      logic [HalfBits-1:0] r;
      if (two) begin
         r = {v[HalfBits-3:0], v[HalfBits-1:HalfBits-2]};
      end else begin
         r = {v[HalfBits-2:0], v[HalfBits-1]};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/des_rks_halves.sv -----
`default_nettype none

module des_rks_halves (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            load,
   input  wire logic [des_rks_pkg::KeyBits-1:0] key,
   input  wire logic                            advance,
   output des_rks_pkg::rks_status_type          status,
   output logic      [des_rks_pkg::Pc1Bits-1:0] cd_next
);
   import des_rks_pkg::*;

   logic [Pc1Bits-1:0]   cd_ff, cd_in;
   logic [RoundBits-1:0] round_ff, round_in;
   logic                 busy_ff, busy_in;
   logic                 two;

   always_comb begin
      two     = SHIFT_TWO[round_ff];
      cd_next = {rot28(cd_ff[Pc1Bits-1:HalfBits], two), rot28(cd_ff[HalfBits-1:0], two)};
   end

   always_comb begin
      cd_in    = cd_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      if (advance) begin
         cd_in    = cd_next;
         round_in = round_ff + RoundBits'(1);
         if (round_ff == LAST_ROUND) begin
            busy_in = 1'b0;
         end
      end
      // a new key overrides the round that just finished
      if (load) begin
         cd_in    = pc1(key);
         round_in = '0;
         busy_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         round_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         round_ff <= round_in;
      end
      cd_ff <= cd_in;
   end

   assign status.busy        = busy_ff;
   assign status.final_round = (round_ff == LAST_ROUND);
   assign status.round       = round_ff;

endmodule

`default_nettype wire

// ----- rtl/des_rks_out.sv -----
`default_nettype none

module des_rks_out (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              advance,
   input  wire logic [des_rks_pkg::Pc1Bits-1:0]   cd_next,
   input  wire des_rks_pkg::rks_status_type       status,
   output logic                                   out_free,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [des_rks_pkg::RspWidth-1:0]  rsp_tdata,
   output logic                                   rsp_tlast
);
   import des_rks_pkg::*;

   logic                 valid_ff, valid_in;
   logic [Pc2Bits-1:0]   key_ff;
   logic [RoundBits-1:0] index_ff;
   logic                 last_ff;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (advance) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         key_ff   <= pc2(cd_next);
         index_ff <= status.round;
         last_ff  <= status.final_round;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RspWidth - Pc2Bits - RoundBits){1'b0}}, index_ff, key_ff};
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

// ----- rtl/des_round_key_schedule.sv -----
`default_nettype none

// DES key schedule: each 64-bit key taken on req_ yields sixteen 48-bit round
// subkeys on rsp_, round 0 first, one per cycle while rsp_tready is high; tlast
// marks round 15. Parity bits are ignored. The rotating C/D half register steps
// once per subkey; the next key is taken in the cycle the sixteenth subkey
// leaves the generator, so keys follow without a gap while rsp_tready is high.
// An accepted key is first loaded into the C/D register, and its first subkey
// is then registered in the output stage that drives rsp_.
module des_round_key_schedule
   import des_rks_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [KeyBits-1:0]  req_tdata,   // [63:0] key_in
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic      [RspWidth-1:0] rsp_tdata,   // [47:0] round_key, [51:48] round_index
   output logic                     rsp_tlast    // last_round
);

   rks_status_type     status;
   logic [Pc1Bits-1:0] cd_next;
   logic               out_free;
   logic               advance;
   logic               load;

   assign advance    = status.busy && out_free;
   assign req_tready = !status.busy || (status.final_round && advance);
   assign load       = req_tvalid && req_tready;

   des_rks_halves u_halves (
      .clock   (clock),
      .reset   (reset),
      .load    (load),
      .key     (req_tdata),
      .advance (advance),
      .status  (status),
      .cd_next (cd_next)
   );

   des_rks_out u_out (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .cd_next    (cd_next),
      .status     (status),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_load_starts_run: assert property (@(posedge clock) disable iff (reset)
      load |=> status.busy && status.round == '0)
      else $error("key load did not start a run at round 0");

   a_ready_only_at_end: assert property (@(posedge clock) disable iff (reset)
      req_tready && status.busy |-> status.final_round && advance)
      else $error("key taken while a run is unfinished");

   a_last_is_round_15: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[Pc2Bits+RoundBits-1:Pc2Bits] == LAST_ROUND)))
      else $error("tlast disagrees with round index");

endmodule

`default_nettype wire
